[rtl/polyline_resample_step_macros.svh]
// ----------------------------------------------------------------------------
// polyline_resample_step_macros.svh
// Assertion macros used by the polyline resampler top level.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_RESAMPLE_STEP_MACROS_SVH
`define POLYLINE_RESAMPLE_STEP_MACROS_SVH

// same-cycle implication
`define PRS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PRS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/prs_pkg.sv]
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types, constants and width helpers of the polyline resampler.
// ----------------------------------------------------------------------------
package prs_pkg;

   localparam int STEP_BITS = 16;
   localparam int OUT_BITS  = 32;
   localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd2;

   typedef enum logic [1:0] {
      MUL_SQUARE,   // |d| * |d|
      MUL_CROSS,    // |d| * |jump|
      MUL_JUMP      // |jump| * |jump|
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        mul_step;
      logic        root_start;
      logic        root_step;
      logic        div_start;
      logic        div_step;
      logic        walk_start;
      logic        walk_step;
      logic        trace_step;
      logic        out_point;
      logic        out_vertex;
   } prs_cmd_type;

   typedef struct packed {
      logic seg;       // vertex closes a nonzero segment
      logic last;      // vertex ends the polyline
      logic near_end;  // squared distance to end within squared step
   } prs_status_type;

   function automatic int root_bits(int cb, int fb);
      return cb + 2 + fb;
   endfunction

   function automatic int quot_bits(int fb);
      return STEP_BITS + 1 + fb;
   endfunction

   function automatic int mul_bits(int cb, int fb);
      return ((cb + 1) > quot_bits(fb)) ? (cb + 1) : quot_bits(fb);
   endfunction

   function automatic int num_bits(int cb, int fb);
      return cb + 1 + STEP_BITS + 2 * fb;
   endfunction

endpackage

[rtl/polyline_resample_step.sv]
// Sequence: a segment vertex runs the bit-serial multipliers, square root and
//   dividers (square, root, divide, cross product, jump square), then its points
//   are counted and then emitted, each emission waiting for a free output slot.
//   Other vertices go from the check straight to idle or to the final vertex.
// Throughput: one vertex in flight; the next is taken once the last point is queued.
// Reset (synchronous, active high) clears the sequencer, held vertex and step (to 2).
// ----------------------------------------------------------------------------
// polyline_resample_step
// Fixed-step polyline densifier: emits points spaced by the step along each
// segment, then the final vertex.
// ----------------------------------------------------------------------------
`include "polyline_resample_step_macros.svh"

module polyline_resample_step import prs_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // input vertex transaction
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OUT_BITS-1:0]  req_vertex_x,
   input  logic [OUT_BITS-1:0]  req_vertex_y,
   input  logic                 req_first_vertex,
   input  logic                 req_last_vertex,
   // result point transaction
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_BITS-1:0]  rsp_point_x,
   output logic [OUT_BITS-1:0]  rsp_point_y,
   output logic                 rsp_run_end,
   output logic                 rsp_truncated,
   // step register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [STEP_BITS-1:0] csr_step_distance
);

   prs_cmd_type    cmd;
   prs_status_type status;

   // The step register is always writable; the user must make writes land while idle (not enforced).
   assign csr_ready = 1'b1;

   // Sequencer: walks the phases square -> root -> divide -> cross product ->
   // jump square, then counts points with the incremental distance walk so the
   // truncation flag is known before the first point leaves, then emits.
   prs_controller #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_run_end   (rsp_run_end),
      .rsp_truncated (rsp_truncated),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath: Q.FRAC_BITS accumulators, two lanes (x and y) of shift-add
   // multiplier and restoring divider, one shared digit-by-digit square root.
   prs_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_valid && csr_ready),
      .csr_step_distance (csr_step_distance),
      .req_vertex_x      (req_vertex_x),
      .req_vertex_y      (req_vertex_y),
      .req_first_vertex  (req_first_vertex),
      .req_last_vertex   (req_last_vertex),
      .cmd               (cmd),
      .status            (status),
      .point_x           (rsp_point_x),
      .point_y           (rsp_point_y)
   );

   // one vertex at a time
   `PRS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accepted a vertex while busy")
   // no datapath commands other than load while idle
   `PRS_ASSERT_IMP(a_idle_quiet, clock, reset, req_ready, (cmd.mul_start || cmd.mul_step || cmd.root_step || cmd.div_step || cmd.walk_step || cmd.trace_step) == 1'b0, "datapath active while idle")
   // output register only reloaded when its slot is free
   `PRS_ASSERT_IMP(a_out_slot_free, clock, reset, cmd.out_point || cmd.out_vertex, !rsp_valid || rsp_ready, "result overwritten before taken")

endmodule

[rtl/prs_datapath.sv]
// ----------------------------------------------------------------------------
// prs_datapath
// Vertex registers, shift-add multipliers, square root, dividers and the
// incremental distance walk of the resampler.
// ----------------------------------------------------------------------------
module prs_datapath import prs_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [STEP_BITS-1:0] csr_step_distance,
   input  logic [OUT_BITS-1:0]  req_vertex_x,
   input  logic [OUT_BITS-1:0]  req_vertex_y,
   input  logic                 req_first_vertex,
   input  logic                 req_last_vertex,
   input  prs_cmd_type          cmd,
   output prs_status_type       status,
   output logic [OUT_BITS-1:0]  point_x,
   output logic [OUT_BITS-1:0]  point_y
);

   localparam int CW   = COORD_BITS;
   localparam int DXW  = CW + 1;
   localparam int LW   = root_bits(COORD_BITS, FRAC_BITS);
   localparam int SQW  = 2 * LW;
   localparam int RW   = LW + 3;
   localparam int QW   = quot_bits(FRAC_BITS);
   localparam int MW   = mul_bits(COORD_BITS, FRAC_BITS);
   localparam int PW   = 2 * MW;
   localparam int NXW  = DXW + STEP_BITS;
   localparam int NUMW = num_bits(COORD_BITS, FRAC_BITS);
   localparam int DRW  = LW + 1;
   localparam int DW   = 2 * (CW + FRAC_BITS) + 5;
   localparam int AW   = CW + FRAC_BITS + 2;

   logic [STEP_BITS-1:0]   step_ff;
   logic                   have_prev_ff;
   logic signed [CW-1:0]   prev_x_ff, prev_y_ff;
   logic signed [CW-1:0]   vx_ff, vy_ff;
   logic                   sx_ff, sy_ff;
   logic [DXW-1:0]         ax_ff, ay_ff;
   logic                   last_ff, seg_ff;
   logic signed [AW-1:0]   cx_ff, cy_ff;
   logic [PW-1:0]          macc_x_ff, macc_y_ff, mca_x_ff, mca_y_ff;
   logic [MW-1:0]          mcb_x_ff, mcb_y_ff;
   logic [SQW-1:0]         rad_ff;
   logic [LW-1:0]          root_ff;
   logic [RW-1:0]          rrem_ff;
   logic [NXW-1:0]         nx_ff, ny_ff;
   logic [NUMW-1:0]        num_x_ff, num_y_ff;
   logic [DRW-1:0]         drem_x_ff, drem_y_ff;
   logic [QW-1:0]          q_x_ff, q_y_ff;
   logic signed [DW-1:0]   dist_ff, proj_ff, jj_ff, lim_ff;
   logic [OUT_BITS-1:0]    point_x_ff, point_y_ff;

   logic signed [CW-1:0]   vx, vy;
   logic signed [DXW-1:0]  dx, dy;
   logic [DXW-1:0]         ax, ay;
   logic [STEP_BITS-1:0]   step_eff;
   logic [MW-1:0]          opa_x, opb_x, opa_y, opb_y;
   logic [PW:0]            sum_xy;
   logic [RW-1:0]          rw, trial;
   logic [DRW:0]           dr_x, dr_y;
   logic signed [AW-1:0]   jx, jy;
   logic signed [AW-FRAC_BITS-1:0] tx, ty;

   always_comb begin
      vx = signed'(req_vertex_x[CW-1:0]);
      vy = signed'(req_vertex_y[CW-1:0]);
      dx = DXW'(vx) - DXW'(prev_x_ff);
      dy = DXW'(vy) - DXW'(prev_y_ff);
      ax = dx[DXW-1] ? unsigned'(-dx) : unsigned'(dx);
      ay = dy[DXW-1] ? unsigned'(-dy) : unsigned'(dy);
      step_eff = (step_ff == '0) ? STEP_BITS'(1) : step_ff;
      sum_xy = {1'b0, macc_x_ff} + {1'b0, macc_y_ff};
      rw = {rrem_ff[RW-3:0], rad_ff[SQW-1 -: 2]};
      trial = RW'({root_ff, 2'b01});
      dr_x = {drem_x_ff, num_x_ff[NUMW-1]};
      dr_y = {drem_y_ff, num_y_ff[NUMW-1]};
      jx = signed'(AW'(q_x_ff));
      jy = signed'(AW'(q_y_ff));
      if (sx_ff) jx = -jx;
      if (sy_ff) jy = -jy;
      // truncate toward zero
      tx = (AW-FRAC_BITS)'(cx_ff >>> FRAC_BITS);
      ty = (AW-FRAC_BITS)'(cy_ff >>> FRAC_BITS);
      if (cx_ff[AW-1] && (cx_ff[FRAC_BITS-1:0] != '0)) tx = tx + 1'b1;
      if (cy_ff[AW-1] && (cy_ff[FRAC_BITS-1:0] != '0)) ty = ty + 1'b1;
      case (cmd.mul_sel)
         MUL_SQUARE: begin
            opa_x = MW'(ax_ff);  opb_x = MW'(ax_ff);
            opa_y = MW'(ay_ff);  opb_y = MW'(ay_ff);
         end
         MUL_CROSS: begin
            opa_x = MW'(ax_ff);  opb_x = MW'(q_x_ff);
            opa_y = MW'(ay_ff);  opb_y = MW'(q_y_ff);
         end
         MUL_JUMP: begin
            opa_x = MW'(q_x_ff); opb_x = MW'(q_x_ff);
            opa_y = MW'(q_y_ff); opb_y = MW'(q_y_ff);
         end
         default: begin
            opa_x = '0; opb_x = '0; opa_y = '0; opb_y = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
      end else begin
         if (csr_write) step_ff <= csr_step_distance;
         if (cmd.load) begin
            prev_x_ff    <= vx;
            prev_y_ff    <= vy;
            have_prev_ff <= !req_last_vertex;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vx_ff   <= vx;
         vy_ff   <= vy;
         ax_ff   <= ax;
         ay_ff   <= ay;
         sx_ff   <= dx[DXW-1];
         sy_ff   <= dy[DXW-1];
         last_ff <= req_last_vertex;
         seg_ff  <= !req_first_vertex && have_prev_ff && ((dx != '0) || (dy != '0));
         cx_ff   <= AW'(prev_x_ff) <<< FRAC_BITS;
         cy_ff   <= AW'(prev_y_ff) <<< FRAC_BITS;
      end
      if (cmd.trace_step) begin
         cx_ff <= cx_ff + jx;
         cy_ff <= cy_ff + jy;
      end

      if (cmd.mul_start) begin
         mca_x_ff  <= PW'(opa_x);
         mca_y_ff  <= PW'(opa_y);
         mcb_x_ff  <= opb_x;
         mcb_y_ff  <= opb_y;
         macc_x_ff <= '0;
         macc_y_ff <= '0;
         if (cmd.mul_sel == MUL_JUMP) proj_ff <= signed'(DW'(sum_xy) << FRAC_BITS);
      end else if (cmd.mul_step) begin
         if (mcb_x_ff[0]) macc_x_ff <= macc_x_ff + mca_x_ff;
         if (mcb_y_ff[0]) macc_y_ff <= macc_y_ff + mca_y_ff;
         mca_x_ff <= mca_x_ff << 1;
         mca_y_ff <= mca_y_ff << 1;
         mcb_x_ff <= mcb_x_ff >> 1;
         mcb_y_ff <= mcb_y_ff >> 1;
      end

      if (cmd.root_start) begin
         rad_ff  <= SQW'(sum_xy) << (2 * FRAC_BITS);
         dist_ff <= signed'(DW'(sum_xy) << (2 * FRAC_BITS));
         lim_ff  <= signed'(DW'(step_eff * step_eff) << (2 * FRAC_BITS));
         nx_ff   <= NXW'(ax_ff) * NXW'(step_eff);
         ny_ff   <= NXW'(ay_ff) * NXW'(step_eff);
         root_ff <= '0;
         rrem_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= rad_ff << 2;
         if (rw >= trial) begin
            rrem_ff <= rw - trial;
            root_ff <= {root_ff[LW-2:0], 1'b1};
         end else begin
            rrem_ff <= rw;
            root_ff <= {root_ff[LW-2:0], 1'b0};
         end
      end

      if (cmd.div_start) begin
         num_x_ff  <= NUMW'(nx_ff) << (2 * FRAC_BITS);
         num_y_ff  <= NUMW'(ny_ff) << (2 * FRAC_BITS);
         drem_x_ff <= '0;
         drem_y_ff <= '0;
         q_x_ff    <= '0;
         q_y_ff    <= '0;
      end else if (cmd.div_step) begin
         num_x_ff <= num_x_ff << 1;
         num_y_ff <= num_y_ff << 1;
         if (dr_x >= (DRW+1)'(root_ff)) begin
            drem_x_ff <= DRW'(dr_x - (DRW+1)'(root_ff));
            q_x_ff    <= {q_x_ff[QW-2:0], 1'b1};
         end else begin
            drem_x_ff <= DRW'(dr_x);
            q_x_ff    <= {q_x_ff[QW-2:0], 1'b0};
         end
         if (dr_y >= (DRW+1)'(root_ff)) begin
            drem_y_ff <= DRW'(dr_y - (DRW+1)'(root_ff));
            q_y_ff    <= {q_y_ff[QW-2:0], 1'b1};
         end else begin
            drem_y_ff <= DRW'(dr_y);
            q_y_ff    <= {q_y_ff[QW-2:0], 1'b0};
         end
      end

      // |E-C-J|^2 = |E-C|^2 - 2(E-C).J + |J|^2
      if (cmd.walk_start) begin
         jj_ff <= signed'(DW'(sum_xy));
      end else if (cmd.walk_step) begin
         dist_ff <= dist_ff - (proj_ff <<< 1) + jj_ff;
         proj_ff <= proj_ff - jj_ff;
      end

      if (cmd.out_point) begin
         point_x_ff <= OUT_BITS'(tx);
         point_y_ff <= OUT_BITS'(ty);
      end else if (cmd.out_vertex) begin
         point_x_ff <= OUT_BITS'(vx_ff);
         point_y_ff <= OUT_BITS'(vy_ff);
      end
   end

   assign status.seg      = seg_ff;
   assign status.last     = last_ff;
   assign status.near_end = (dist_ff <= lim_ff);
   assign point_x         = point_x_ff;
   assign point_y         = point_y_ff;

endmodule

[rtl/prs_controller.sv]
// ----------------------------------------------------------------------------
// prs_controller
// Sequencer of the resampler: phase timing, point count and output stage.
// ----------------------------------------------------------------------------
module prs_controller import prs_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16,
   parameter int MAX_POINTS = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_run_end,
   output logic           rsp_truncated,
   input  prs_status_type status,
   output prs_cmd_type    cmd
);

   localparam int MW   = mul_bits(COORD_BITS, FRAC_BITS);
   localparam int LW   = root_bits(COORD_BITS, FRAC_BITS);
   localparam int NUMW = num_bits(COORD_BITS, FRAC_BITS);
   localparam int CTW  = $clog2(NUMW + 1);
   localparam int KW   = $clog2(MAX_POINTS + 1);
   localparam logic [CTW-1:0] MUL_END  = CTW'(MW);
   localparam logic [CTW-1:0] ROOT_END = CTW'(LW);
   localparam logic [CTW-1:0] DIV_END  = CTW'(NUMW);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SQUARE, S_ROOT, S_DIVIDE, S_CROSS, S_JUMP,
      S_COUNT, S_EMIT, S_FINAL
   } state_type;

   state_type      state_ff, state_in;
   logic [CTW-1:0] cyc_ff, cyc_in;
   logic [KW-1:0]  cnt_ff, cnt_in, idx_ff, idx_in, cap;
   logic           cut_ff, cut_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           run_end_ff, run_end_in;
   logic           trunc_ff, trunc_in;
   logic           slot_free;

   always_comb begin
      state_in     = state_ff;
      cyc_in       = cyc_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      cut_in       = cut_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      run_end_in   = run_end_ff;
      trunc_in     = trunc_ff;
      cmd          = '0;
      slot_free    = !rsp_valid_ff || rsp_ready;
      cap          = KW'(MAX_POINTS) - KW'(status.last);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cut_in   = 1'b0;
               cyc_in   = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.seg)       state_in = S_SQUARE;
            else if (status.last) state_in = S_FINAL;
            else                  state_in = S_IDLE;
         end
         S_SQUARE, S_CROSS, S_JUMP: begin
            cmd.mul_sel = (state_ff == S_SQUARE) ? MUL_SQUARE :
                          (state_ff == S_CROSS)  ? MUL_CROSS  : MUL_JUMP;
            if (cyc_ff == '0) cmd.mul_start = 1'b1;
            else              cmd.mul_step  = 1'b1;
            cyc_in = cyc_ff + 1'b1;
            if (cyc_ff == MUL_END) begin
               cyc_in   = '0;
               state_in = (state_ff == S_SQUARE) ? S_ROOT :
                          (state_ff == S_CROSS)  ? S_JUMP : S_COUNT;
            end
         end
         S_ROOT: begin
            if (cyc_ff == '0) cmd.root_start = 1'b1;
            else              cmd.root_step  = 1'b1;
            cyc_in = cyc_ff + 1'b1;
            if (cyc_ff == ROOT_END) begin
               cyc_in   = '0;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (cyc_ff == '0) cmd.div_start = 1'b1;
            else              cmd.div_step  = 1'b1;
            cyc_in = cyc_ff + 1'b1;
            if (cyc_ff == DIV_END) begin
               cyc_in   = '0;
               state_in = S_CROSS;
            end
         end
         S_COUNT: begin
            if (cyc_ff == '0) begin
               cmd.walk_start = 1'b1;
               cnt_in         = '0;
               cyc_in         = CTW'(1);
            end else if (cnt_ff >= cap) begin
               cut_in   = 1'b1;
               idx_in   = '0;
               cyc_in   = '0;
               state_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (status.near_end) begin
                  idx_in   = '0;
                  cyc_in   = '0;
                  state_in = S_EMIT;
               end else begin
                  cmd.walk_step = 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               cmd.out_point  = 1'b1;
               cmd.trace_step = 1'b1;
               rsp_valid_in   = 1'b1;
               run_end_in     = (idx_ff == cnt_ff - 1'b1) && !status.last;
               trunc_in       = cut_ff;
               idx_in         = idx_ff + 1'b1;
               if (idx_ff == cnt_ff - 1'b1)
                  state_in = status.last ? S_FINAL : S_IDLE;
            end
         end
         S_FINAL: begin
            if (slot_free) begin
               cmd.out_vertex = 1'b1;
               rsp_valid_in   = 1'b1;
               run_end_in     = 1'b1;
               trunc_in       = cut_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cyc_ff       <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         cut_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         run_end_ff   <= 1'b0;
         trunc_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cyc_ff       <= cyc_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         cut_ff       <= cut_in;
         rsp_valid_ff <= rsp_valid_in;
         run_end_ff   <= run_end_in;
         trunc_ff     <= trunc_in;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_end   = run_end_ff;
   assign rsp_truncated = trunc_ff;

endmodule
